FILE: design/rhsl_pkg.sv
// shared constants and types of the rgb/hsl adjust block
package rhsl_pkg;

  // default number of fraction bits of the internal unit fractions
  localparam int FRAC_BITS_DEF = 16;

  // field widths
  localparam int PIX_W = 8;
  localparam int HUE_W = 10;
  localparam int SAT_W = 18;
  localparam int LIG_W = 19;

  // fraction bits of the saturation offset and light factor registers
  localparam int SAT_FRAC   = 16;
  localparam int LIGHT_FRAC = 16;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 19;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HUE_SHIFT    = 2'd0,
    CFG_SAT_OFFSET   = 2'd1,
    CFG_LIGHT_FACTOR = 2'd2
  } cfg_reg_e;

  localparam logic [LIG_W-1:0] LIGHT_RESET = 19'd65536;

  // divider operand width, holds six times the largest chroma
  localparam int DIV_W = 11;

  // piece of the hue-to-channel curve
  typedef enum logic [1:0] {
    SEG_RISE,
    SEG_TOP,
    SEG_FALL,
    SEG_BASE
  } hue_seg_e;

endpackage

FILE: design/rhsl_in_if.sv
// pixel input channel
interface rhsl_in_if import rhsl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red_in;
  logic [PIX_W-1:0] green_in;
  logic [PIX_W-1:0] blue_in;
  logic [PIX_W-1:0] alpha_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  output alpha_in, input ready);
  modport sink (input valid, input red_in, input green_in, input blue_in,
                input alpha_in, output ready);
endinterface

FILE: design/rhsl_out_if.sv
// pixel output channel
interface rhsl_out_if import rhsl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red_out;
  logic [PIX_W-1:0] green_out;
  logic [PIX_W-1:0] blue_out;
  logic [PIX_W-1:0] alpha_out;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output alpha_out, input ready);
  modport sink (input valid, input red_out, input green_out, input blue_out,
                input alpha_out, output ready);
endinterface

FILE: design/rgb_hsl_adjust_unit.sv
// Hue, saturation and lightness adjustment of an RGBA pixel stream. Each word is
// turned into HSL, the hue is rotated, saturation offset and clamped, lightness
// scaled and clamped, then turned back into RGB; alpha passes through. One pixel
// per clock is taken in steady state. Hue and saturation go through bit-per-stage
// dividers of FRAC_BITS + 1 stages (the lightness quotient comes from a reciprocal
// multiply that travels beside them), followed by the conversion and output stages.
// While a finished word waits in the output register the earlier stages keep
// advancing into empty slots; the input stalls only once the last stage and the
// output register both hold words.
// Configuration should be written only while the pipeline is empty, since a write
// also reaches words that are still in flight.
module rgb_hsl_adjust_unit import rhsl_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  rhsl_in_if.sink               pix_i,
  rhsl_out_if.source            pix_o
);

  localparam int F     = FRAC_BITS;
  localparam int NDIV  = F + 1;
  localparam int NCH   = 3;
  localparam int MUL_W = F + 8;
  localparam longint unsigned HUE_MUL = ((64'd1 << (F + 13)) + 64'd44) / 64'd45;
  localparam logic [MUL_W-1:0] HUE_MUL_C = MUL_W'(HUE_MUL);
  localparam logic [F:0] ONE_Q = {1'b1, {F{1'b0}}};
  localparam int LF_W = F + 1 + LIG_W - LIGHT_FRAC;
  // lightness reciprocal: (max + min) * ONE / 510, exact for sums up to 510
  localparam int LREC_K = 18;
  localparam int LREC_W = F + 10;
  localparam longint unsigned LIG_REC = ((64'd1 << (F + LREC_K)) + 64'd509) / 64'd510;
  localparam logic [LREC_W-1:0] LIG_REC_C = LREC_W'(LIG_REC);

  // configuration registers
  logic [HUE_W-1:0] hue_q;
  logic [SAT_W-1:0] sat_q;
  logic [LIG_W-1:0] light_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_q   <= '0;
      sat_q   <= '0;
      light_q <= LIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_HUE_SHIFT:    hue_q   <= cfg_data_i[HUE_W-1:0];
        CFG_SAT_OFFSET:   sat_q   <= cfg_data_i[SAT_W-1:0];
        CFG_LIGHT_FACTOR: light_q <= cfg_data_i[LIG_W-1:0];
        default: ;
      endcase
    end
  end

  // hue shift in turns: trunc(deg * ONE / 360) via reciprocal multiply
  logic [HUE_W-1:0]       deg_mag;
  logic [HUE_W+MUL_W-1:0] deg_prod;
  logic [F:0]             shift_mag;
  logic signed [F+1:0]    shift_d, shift_q;

  assign deg_mag   = hue_q[HUE_W-1] ? HUE_W'(-hue_q) : hue_q;
  assign deg_prod  = (HUE_W+MUL_W)'(deg_mag) * (HUE_W+MUL_W)'(HUE_MUL_C);
  assign shift_mag = deg_prod[16 +: F+1];
  assign shift_d   = hue_q[HUE_W-1] ? -$signed({1'b0, shift_mag})
                                    : $signed({1'b0, shift_mag});

  // saturation offset rescaled to the internal fraction, toward zero
  logic [SAT_W-1:0]    sat_mag;
  logic [SAT_W+F-1:0]  sat_ext;
  logic [F+1:0]        off_mag;
  logic signed [F+2:0] sat_off_d, sat_off_q;

  assign sat_mag = sat_q[SAT_W-1] ? SAT_W'(-sat_q) : sat_q;

  if (F >= SAT_FRAC) begin : g_sat_up
    assign sat_ext = (SAT_W+F)'(sat_mag) << (F - SAT_FRAC);
  end else begin : g_sat_dn
    assign sat_ext = (SAT_W+F)'(sat_mag) >> (SAT_FRAC - F);
  end

  assign off_mag   = sat_ext[F+1:0];
  assign sat_off_d = sat_q[SAT_W-1] ? -$signed({1'b0, off_mag})
                                    : $signed({1'b0, off_mag});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q   <= '0;
      sat_off_q <= '0;
    end else begin
      shift_q   <= shift_d;
      sat_off_q <= sat_off_d;
    end
  end

  // pipeline advance: stall only when the last stage and the output both hold words
  logic en;
  logic vl;
  logic out_valid_q;
  logic load_out;

  assign en          = !vl || !out_valid_q || pix_o.ready;
  assign load_out    = vl && (!out_valid_q || pix_o.ready);
  assign pix_i.ready = en;

  // stage 1: max, min, chroma, divider operands
  logic [PIX_W-1:0] r, g, b, mx, mn, d;
  logic [PIX_W:0]   s, sden;
  logic [DIV_W-1:0] d1, d6, hnum;

  assign r = pix_i.red_in;
  assign g = pix_i.green_in;
  assign b = pix_i.blue_in;

  always_comb begin
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
  end

  assign d    = mx - mn;
  assign s    = (PIX_W+1)'(mx) + (PIX_W+1)'(mn);
  assign sden = (s < (PIX_W+1)'(255)) ? s : ((PIX_W+1)'(510) - s);
  assign d1   = DIV_W'(d);
  assign d6   = (d1 << 2) + (d1 << 1);

  always_comb begin
    if (r == mx) begin
      hnum = (g >= b) ? (DIV_W'(g) - DIV_W'(b)) : (d6 + DIV_W'(g) - DIV_W'(b));
    end else if (g == mx) begin
      hnum = (d1 << 1) + DIV_W'(b) - DIV_W'(r);
    end else begin
      hnum = (d1 << 2) + DIV_W'(r) - DIV_W'(g);
    end
  end

  logic             v1_q;
  logic [DIV_W-1:0] hnum1_q, hden1_q, snum1_q, sden1_q, lnum1_q;
  logic             grey1_q;
  logic [PIX_W-1:0] alpha1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      hnum1_q  <= hnum;
      hden1_q  <= d6;
      snum1_q  <= d1;
      sden1_q  <= DIV_W'(sden);
      lnum1_q  <= DIV_W'(s);
      grey1_q  <= (d == '0);
      alpha1_q <= pix_i.alpha_in;
    end
  end

  // fixed-point dividers for hue and saturation
  logic [F:0] hq, sq, lq;

  rhsl_div #(.FRAC_BITS(F)) u_div_hue (
    .clk_i (clk_i), .en_i (en), .num_i (hnum1_q), .den_i (hden1_q), .quo_o (hq)
  );

  rhsl_div #(.FRAC_BITS(F)) u_div_sat (
    .clk_i (clk_i), .en_i (en), .num_i (snum1_q), .den_i (sden1_q), .quo_o (sq)
  );

  // lightness by reciprocal multiply
  logic [LREC_W+DIV_W-1:0] lrec_prod;
  logic [F:0]              lq_d;

  assign lrec_prod = (LREC_W+DIV_W)'(lnum1_q) * (LREC_W+DIV_W)'(LIG_REC_C);
  assign lq_d      = lrec_prod[LREC_K +: F+1];

  // side data travels beside the dividers
  logic             dv_q [NDIV];
  logic             dg_q [NDIV];
  logic [PIX_W-1:0] da_q [NDIV];
  logic [F:0]       dl_q [NDIV];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dg_q[0] <= grey1_q;
      da_q[0] <= alpha1_q;
      dl_q[0] <= lq_d;
      for (int k = 1; k < NDIV; k++) begin
        dg_q[k] <= dg_q[k-1];
        da_q[k] <= da_q[k-1];
        dl_q[k] <= dl_q[k-1];
      end
    end
  end

  assign lq = dl_q[NDIV-1];

  // stage 2: hue wrap, saturation clamp, lightness product
  logic [F-1:0]         hraw, h2_d;
  logic [F:0]           sraw, sat2_d;
  logic signed [F+3:0]  ssum;
  logic [F+LIG_W:0]     lprod;

  assign hraw  = dg_q[NDIV-1] ? '0 : hq[F-1:0];
  assign h2_d  = hraw + shift_q[F-1:0];
  assign sraw  = dg_q[NDIV-1] ? '0 : sq;
  assign ssum  = $signed({3'b000, sraw}) + (F+4)'(sat_off_q);
  assign lprod = (F+1+LIG_W)'(lq) * (F+1+LIG_W)'(light_q);

  always_comb begin
    if (ssum < 0) begin
      sat2_d = '0;
    end else if (ssum > $signed({3'b000, ONE_Q})) begin
      sat2_d = ONE_Q;
    end else begin
      sat2_d = ssum[F:0];
    end
  end

  logic             v2_q;
  logic [F-1:0]     h2_q;
  logic [F:0]       sat2_q;
  logic [F+LIG_W:0] lprod2_q;
  logic [PIX_W-1:0] alpha2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      h2_q     <= h2_d;
      sat2_q   <= sat2_d;
      lprod2_q <= lprod;
      alpha2_q <= da_q[NDIV-1];
    end
  end

  // stage 3: lightness clamp, v2 product
  logic [LF_W-1:0] lig_full;
  logic [F:0]      lig3_d;
  logic            lo3_d;
  logic [F+1:0]    mop;
  logic [2*F+2:0]  p3_d;

  assign lig_full = lprod2_q[F+LIG_W:LIGHT_FRAC];
  assign lig3_d   = (lig_full > LF_W'(ONE_Q)) ? ONE_Q : lig_full[F:0];
  assign lo3_d    = (lig3_d[F:F-1] == 2'b00);
  assign mop      = lo3_d ? ((F+2)'(ONE_Q) + (F+2)'(sat2_q)) : (F+2)'(sat2_q);
  assign p3_d     = (2*F+3)'(lig3_d) * (2*F+3)'(mop);

  logic             v3_q;
  logic [F-1:0]     h3_q;
  logic [F:0]       lig3_q, sat3_q;
  logic             lo3_q;
  logic [2*F+2:0]   p3_q;
  logic [PIX_W-1:0] alpha3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      h3_q     <= h2_q;
      lig3_q   <= lig3_d;
      sat3_q   <= sat2_q;
      lo3_q    <= lo3_d;
      p3_q     <= p3_d;
      alpha3_q <= alpha2_q;
    end
  end

  // stage 4: v1 and v2
  logic [F+2:0]        ph;
  logic signed [F+3:0] v2s, v1s, v1c, v2c;

  assign ph  = p3_q[2*F+2:F];
  assign v2s = lo3_q ? $signed({1'b0, ph})
                     : ($signed((F+4)'(lig3_q)) + $signed((F+4)'(sat3_q))
                        - $signed({1'b0, ph}));
  assign v1s = $signed((F+4)'({lig3_q, 1'b0})) - v2s;
  assign v1c = (v1s < 0) ? '0 : v1s;
  assign v2c = (v2s < v1c) ? v1c : v2s;

  logic             v4_q;
  logic [F-1:0]     h4_q;
  logic [F+1:0]     v14_q, v24_q;
  logic [PIX_W-1:0] alpha4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      h4_q     <= h3_q;
      v14_q    <= v1c[F+1:0];
      v24_q    <= v2c[F+1:0];
      alpha4_q <= alpha3_q;
    end
  end

  // stages 5 to 7: per-channel hue curve
  logic [PIX_W-1:0] red_b, green_b, blue_b;

  rhsl_chan #(.FRAC_BITS(F), .HUE_OFS(1)) u_chan_red (
    .clk_i (clk_i), .en_i (en), .v1_i (v14_q), .v2_i (v24_q), .hue_i (h4_q),
    .byte_o (red_b)
  );

  rhsl_chan #(.FRAC_BITS(F), .HUE_OFS(0)) u_chan_green (
    .clk_i (clk_i), .en_i (en), .v1_i (v14_q), .v2_i (v24_q), .hue_i (h4_q),
    .byte_o (green_b)
  );

  rhsl_chan #(.FRAC_BITS(F), .HUE_OFS(-1)) u_chan_blue (
    .clk_i (clk_i), .en_i (en), .v1_i (v14_q), .v2_i (v24_q), .hue_i (h4_q),
    .byte_o (blue_b)
  );

  logic             cv_q [NCH];
  logic [PIX_W-1:0] ca_q [NCH];

  always_ff @(posedge clk_i) begin
    if (en) begin
      ca_q[0] <= alpha4_q;
      for (int k = 1; k < NCH; k++) begin
        ca_q[k] <= ca_q[k-1];
      end
    end
  end

  // valid bits of every stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      for (int k = 0; k < NDIV; k++) dv_q[k] <= 1'b0;
      for (int k = 0; k < NCH; k++) cv_q[k] <= 1'b0;
    end else if (en) begin
      v1_q    <= pix_i.valid;
      dv_q[0] <= v1_q;
      for (int k = 1; k < NDIV; k++) dv_q[k] <= dv_q[k-1];
      v2_q    <= dv_q[NDIV-1];
      v3_q    <= v2_q;
      v4_q    <= v3_q;
      cv_q[0] <= v4_q;
      for (int k = 1; k < NCH; k++) cv_q[k] <= cv_q[k-1];
    end
  end

  assign vl = cv_q[NCH-1];

  // output register
  logic [PIX_W-1:0] red_q, green_q, blue_q, alpha_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (pix_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      red_q   <= red_b;
      green_q <= green_b;
      blue_q  <= blue_b;
      alpha_q <= ca_q[NCH-1];
    end
  end

  assign pix_o.valid     = out_valid_q;
  assign pix_o.red_out   = red_q;
  assign pix_o.green_out = green_q;
  assign pix_o.blue_out  = blue_q;
  assign pix_o.alpha_out = alpha_q;

endmodule

FILE: design/rhsl_div.sv
// pipelined restoring divider, one quotient bit per stage, num <= den
module rhsl_div import rhsl_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [DIV_W-1:0]     num_i,
  input  logic [DIV_W-1:0]     den_i,
  output logic [FRAC_BITS:0]   quo_o
);

  localparam int NST  = FRAC_BITS + 1;
  localparam int RW   = DIV_W + 1;

  logic [RW-1:0]        rem_q [NST];
  logic [DIV_W-1:0]     den_q [NST];
  logic [FRAC_BITS:0]   quo_q [NST];

  for (genvar k = 0; k < NST; k++) begin : g_step
    logic [RW-1:0]      rem_in;
    logic [FRAC_BITS:0] quo_in;
    logic [DIV_W-1:0]   den_in;
    logic               ge;

    // first step takes the integer bit, later steps double the remainder
    if (k == 0) begin : g_first
      assign rem_in = RW'(num_i);
      assign quo_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = {rem_q[k-1][RW-2:0], 1'b0};
      assign quo_in = quo_q[k-1];
      assign den_in = den_q[k-1];
    end

    assign ge = (rem_in >= RW'(den_in));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? (rem_in - RW'(den_in)) : rem_in;
        den_q[k] <= den_in;
        quo_q[k] <= {quo_in[FRAC_BITS-1:0], ge};
      end
    end
  end

  assign quo_o = quo_q[NST-1];

endmodule

FILE: design/rhsl_chan.sv
// hue-to-channel evaluation of one color channel, three register stages
module rhsl_chan import rhsl_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int HUE_OFS   = 0
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [FRAC_BITS+1:0] v1_i,
  input  logic [FRAC_BITS+1:0] v2_i,
  input  logic [FRAC_BITS-1:0] hue_i,
  output logic [PIX_W-1:0]     byte_o
);

  localparam int F = FRAC_BITS;
  localparam int THIRD = (1 << F) / 3;
  localparam int TWO_THIRDS = (2 * (1 << F)) / 3;
  localparam logic [F:0] ONE_Q = {1'b1, {F{1'b0}}};
  localparam logic [F:0] TT_Q = (F+1)'(TWO_THIRDS);
  localparam logic signed [F+1:0] OFS_V = (F+2)'(HUE_OFS * THIRD);
  localparam logic signed [F+1:0] ONE_S = $signed({1'b0, ONE_Q});

  // stage 1: hue position, curve piece and slope
  logic signed [F+1:0] vh_raw;
  logic signed [F+1:0] vh_adj;
  logic [F:0]          vh;
  logic [F+3:0]        vh6;
  logic [F+3:0]        fall6;
  logic [F:0]          fall_d;
  hue_seg_e            seg_d;
  logic [F:0]          t_d;

  assign vh_raw = $signed({2'b00, hue_i}) + OFS_V;

  always_comb begin
    vh_adj = vh_raw;
    if (vh_raw < 0) begin
      vh_adj = vh_raw + ONE_S;
    end else if (vh_raw > ONE_S) begin
      vh_adj = vh_raw - ONE_S;
    end
  end

  assign vh     = vh_adj[F:0];
  assign vh6    = (F+4)'(vh) * (F+4)'(6);
  assign fall_d = TT_Q - vh;
  assign fall6  = (F+4)'(fall_d) * (F+4)'(6);

  always_comb begin
    if (vh6 < (F+4)'(ONE_Q)) begin
      seg_d = SEG_RISE;
      t_d   = vh6[F:0];
    end else if (vh[F:F-1] == 2'b00) begin
      seg_d = SEG_TOP;
      t_d   = '0;
    end else if ((F+3)'(vh) * (F+3)'(3) < (F+3)'({ONE_Q, 1'b0})) begin
      seg_d = SEG_FALL;
      t_d   = fall6[F:0];
    end else begin
      seg_d = SEG_BASE;
      t_d   = '0;
    end
  end

  hue_seg_e   seg1_q;
  logic [F:0] t1_q;
  logic [F+1:0] dv1_q, v11_q, v21_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      seg1_q <= seg_d;
      t1_q   <= t_d;
      dv1_q  <= v2_i - v1_i;
      v11_q  <= v1_i;
      v21_q  <= v2_i;
    end
  end

  // stage 2: slope product
  logic [2*F+2:0] prod;
  assign prod = (2*F+3)'(dv1_q) * (2*F+3)'(t1_q);

  hue_seg_e     seg2_q;
  logic [F+2:0] pr2_q;
  logic [F+1:0] v12_q, v22_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      seg2_q <= seg1_q;
      pr2_q  <= prod[2*F+2:F];
      v12_q  <= v11_q;
      v22_q  <= v21_q;
    end
  end

  // stage 3: pick curve value, clamp, scale to a byte
  logic [F+2:0] val;
  logic [F:0]   val_c;
  logic [F+8:0] scaled;

  always_comb begin
    case (seg2_q)
      SEG_RISE: val = (F+3)'(v12_q) + pr2_q;
      SEG_FALL: val = (F+3)'(v12_q) + pr2_q;
      SEG_TOP:  val = (F+3)'(v22_q);
      SEG_BASE: val = (F+3)'(v12_q);
      default:  val = (F+3)'(v12_q);
    endcase
  end

  assign val_c  = (val > (F+3)'(ONE_Q)) ? ONE_Q : val[F:0];
  assign scaled = {val_c, 8'b0} - (F+9)'(val_c);

  logic [PIX_W-1:0] byte_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      byte_q <= scaled[F+7:F];
    end
  end

  assign byte_o = byte_q;

endmodule

FILE: sim/rgb_hsl_adjust_unit_tb.sv
// self-checking testbench of the rgb/hsl adjust block with a fixed-point pixel predictor
`timescale 1ns / 100ps

module rgb_hsl_adjust_unit_tb;
  import rhsl_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam longint ONE_FX = longint'(1) << FB;
  localparam longint THIRD_FX = ONE_FX / 3;
  localparam longint TWO_THIRDS_FX = (2 * ONE_FX) / 3;
  localparam int LATENCY = FB + 9;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] alpha;
  } pixel_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  rhsl_in_if pix_in ();
  rhsl_out_if pix_out ();

  rgb_hsl_adjust_unit #(.FRAC_BITS(FB)) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .pix_i(pix_in.sink),
    .pix_o(pix_out.source)
  );

  // predictor copy of the registers
  logic [HUE_W-1:0] hue_shift_q;
  logic [SAT_W-1:0] sat_offset_q;
  logic [LIG_W-1:0] light_factor_q;

  pixel_t adjusted_q[$];
  int mismatch_cnt;
  int pixels_checked;
  int configs_done;
  longint cycle_cnt = 0;
  bit idle_enable;

  // clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic longint clamp_unit(longint x);
    if (x < 0) return 0;
    if (x > ONE_FX) return ONE_FX;
    return x;
  endfunction

  // level of the hue-to-channel curve at one hue position, over all its pieces
  function automatic longint hue_level(longint v1, longint v2, longint vh);
    if (vh < 0) vh += ONE_FX;
    if (vh > ONE_FX) vh -= ONE_FX;
    if (6 * vh < ONE_FX) return v1 + (((v2 - v1) * 6 * vh) >>> FB);
    if (2 * vh < ONE_FX) return v2;
    if (3 * vh < 2 * ONE_FX) return v1 + (((v2 - v1) * (TWO_THIRDS_FX - vh) * 6) >>> FB);
    return v1;
  endfunction

  function automatic logic [PIX_W-1:0] level_byte(longint v);
    longint c;
    c = clamp_unit(v);
    return PIX_W'((c * 255) >>> FB);
  endfunction

  // expected adjusted pixel
  function automatic pixel_t adjust_pixel(pixel_t px);
    longint r, g, b, mx, mn, d, s, hue, sat, lig, n, shift, v1, v2;
    pixel_t res;
    r = px.red;
    g = px.green;
    b = px.blue;
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    s = mx + mn;
    lig = (s * ONE_FX) / 510;
    hue = 0;
    sat = 0;
    if (d != 0) begin
      if (s < 255) sat = (d * ONE_FX) / s;
      else sat = (d * ONE_FX) / (510 - s);
      if (r == mx) begin
        n = g - b;
        if (n < 0) n += 6 * d;
      end else if (g == mx) begin
        n = 2 * d + b - r;
      end else begin
        n = 4 * d + r - g;
      end
      hue = (n * ONE_FX) / (6 * d);
    end
    shift = (longint'($signed(hue_shift_q)) * ONE_FX) / 360;
    hue = ((hue + shift) % ONE_FX + ONE_FX) % ONE_FX;
    sat = clamp_unit(sat + (longint'($signed(sat_offset_q)) * ONE_FX) / 65536);
    lig = (lig * longint'(light_factor_q)) >>> LIGHT_FRAC;
    if (lig > ONE_FX) lig = ONE_FX;
    if (sat == 0) begin
      res.red = level_byte(lig);
      res.green = res.red;
      res.blue = res.red;
    end else begin
      if (2 * lig < ONE_FX) v2 = (lig * (ONE_FX + sat)) >>> FB;
      else v2 = lig + sat - ((sat * lig) >>> FB);
      v1 = 2 * lig - v2;
      if (v1 < 0) v1 = 0;
      if (v2 < v1) v2 = v1;
      res.red = level_byte(hue_level(v1, v2, hue + THIRD_FX));
      res.green = level_byte(hue_level(v1, v2, hue));
      res.blue = level_byte(hue_level(v1, v2, hue - THIRD_FX));
    end
    res.alpha = px.alpha;
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("pixel %0d: %s got %0d expected %0d", pixels_checked, what, got, want);
    mismatch_cnt++;
  endtask

  task automatic idle_burst();
    repeat ($urandom_range(1, 15)) @(negedge clk_i);
  endtask

  // send one word
  task automatic send_pixel(pixel_t px);
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      pix_in.valid <= 1'b0;
      idle_burst();
    end
    pix_in.valid <= 1'b1;
    pix_in.red_in <= px.red;
    pix_in.green_in <= px.green;
    pix_in.blue_in <= px.blue;
    pix_in.alpha_in <= px.alpha;
    do @(posedge clk_i); while (!pix_in.ready);
    adjusted_q.push_back(adjust_pixel(px));
    @(negedge clk_i);
  endtask

  function automatic pixel_t random_pixel();
    pixel_t px;
    px = pixel_t'($urandom);
    case ($urandom_range(0, 5))
      0: begin
        px.green = px.red;
        px.blue = px.red;
      end
      1: px.green = px.red;
      2: px.blue = $urandom_range(0, 1) ? 8'd0 : 8'd255;
      default: ;
    endcase
    return px;
  endfunction

  // wait for outstanding words, then let the pipeline drain
  task automatic drain();
    pix_in.valid <= 1'b0;
    while (adjusted_q.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_HUE_SHIFT: hue_shift_q = data[HUE_W-1:0];
      CFG_SAT_OFFSET: sat_offset_q = data[SAT_W-1:0];
      CFG_LIGHT_FACTOR: light_factor_q = data[LIG_W-1:0];
      default: ;
    endcase
    configs_done++;
  endtask

  task automatic set_adjust(int hue, int sat, int light);
    drain();
    write_reg(CFG_HUE_SHIFT, CFG_DATA_W'(hue));
    write_reg(CFG_SAT_OFFSET, CFG_DATA_W'(sat));
    write_reg(CFG_LIGHT_FACTOR, CFG_DATA_W'(light));
    repeat (3) @(negedge clk_i);
  endtask

  // extremes, greys, primaries, every maximum channel
  task automatic test_directed();
    pixel_t list[$];
    list = '{
      '{8'd0, 8'd0, 8'd0, 8'd0}, '{8'd255, 8'd255, 8'd255, 8'd255},
      '{8'd128, 8'd128, 8'd128, 8'd170}, '{8'd255, 8'd0, 8'd0, 8'd85},
      '{8'd0, 8'd255, 8'd0, 8'd1}, '{8'd0, 8'd0, 8'd255, 8'd254},
      '{8'd255, 8'd255, 8'd0, 8'd0}, '{8'd0, 8'd255, 8'd255, 8'd0},
      '{8'd255, 8'd0, 8'd255, 8'd0}, '{8'd200, 8'd10, 8'd100, 8'd0},
      '{8'd10, 8'd200, 8'd100, 8'd0}, '{8'd10, 8'd100, 8'd200, 8'd0},
      '{8'd1, 8'd0, 8'd0, 8'd0}, '{8'd255, 8'd254, 8'd254, 8'd0},
      '{8'd127, 8'd128, 8'd127, 8'd0}, '{8'd128, 8'd127, 8'd127, 8'd0},
      '{8'd100, 8'd50, 8'd50, 8'd0}, '{8'd50, 8'd50, 8'd100, 8'd0}};
    foreach (list[i]) send_pixel(list[i]);
  endtask

  task automatic test_random(int count);
    repeat (count) send_pixel(random_pixel());
  endtask

  // a few register settings, extremes included
  task automatic test_settings();
    set_adjust(360, 65536, 262143);
    test_directed();
    test_random(60);
    set_adjust(-360, -65536, 0);
    test_random(40);
    set_adjust(-512, 131071, 524287);
    test_random(40);
    set_adjust(511, -131072, 32768);
    test_random(40);
    set_adjust(1, 1, 1);
    test_random(40);
    drain();
    write_reg(cfg_reg_e'(2'd3), '1);
    set_adjust($urandom_range(0, 720) - 360, $urandom_range(0, 131072) - 65536,
               $urandom_range(0, 262144));
    test_random(200);
  endtask

  // output side: random stalls, check each word
  initial begin
    pix_out.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (idle_enable && $urandom_range(0, 7) == 0) begin
        pix_out.ready <= 1'b0;
        idle_burst();
      end
      pix_out.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && pix_out.valid && pix_out.ready) begin
      if (adjusted_q.size() == 0) begin
        report_mismatch("unexpected word, red", pix_out.red_out, 0);
      end else begin
        want = adjusted_q.pop_front();
        if (pix_out.red_out !== want.red) report_mismatch("red", pix_out.red_out, want.red);
        if (pix_out.green_out !== want.green)
          report_mismatch("green", pix_out.green_out, want.green);
        if (pix_out.blue_out !== want.blue) report_mismatch("blue", pix_out.blue_out, want.blue);
        if (pix_out.alpha_out !== want.alpha)
          report_mismatch("alpha", pix_out.alpha_out, want.alpha);
      end
      pixels_checked++;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_HUE_SHIFT;
    cfg_data_i = '0;
    pix_in.valid = 1'b0;
    pix_in.red_in = '0;
    pix_in.green_in = '0;
    pix_in.blue_in = '0;
    pix_in.alpha_in = '0;
    hue_shift_q = '0;
    sat_offset_q = '0;
    light_factor_q = LIGHT_RESET;
    mismatch_cnt = 0;
    pixels_checked = 0;
    configs_done = 0;
    idle_enable = 1'b1;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(150);
    test_settings();
    idle_enable = 1'b0;
    test_random(150);
    drain();
    $display("checked %0d pixels over %0d register writes", pixels_checked, configs_done);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
